### rtl/mesh_parent_route_engine_assert.svh
// ----------------------------------------------------------------------------
// mesh parent route engine assertion macros
// shared property forms for the checker, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef MESH_PARENT_ROUTE_ENGINE_ASSERT_SVH
`define MESH_PARENT_ROUTE_ENGINE_ASSERT_SVH

// same-cycle implication
`define MPRE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpre assertion failed");

// next-cycle implication
`define MPRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpre assertion failed");

`endif

### rtl/mpre_pkg.sv
// ----------------------------------------------------------------------------
// mpre_pkg
// types, codes and helpers of the mesh parent route engine
// ----------------------------------------------------------------------------
package mpre_pkg;

    localparam int ID_W      = 10;
    localparam int TIME_W    = 32;
    localparam int HOP_W     = 5;
    localparam int LEN_W     = 4;
    localparam int REG_IDX_W = 1;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_RELAYS_DEF = 16;
    localparam int MAX_DEPTH_DEF  = 12;

    localparam logic [HOP_W-1:0] HOP_SAT = 5'd31;

    localparam logic [ID_W-1:0] LOCAL_ID_RST   = 10'd1;
    localparam logic [ID_W-1:0] NODE_LIMIT_RST = 10'd1023;

    typedef enum logic [1:0]
    {
        OP_SET_VALID = 2'd0,
        OP_APPEND    = 2'd1,
        OP_COMMIT    = 2'd2,
        OP_SELECT    = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE     = 2'd0,
        ST_ROUTE    = 2'd1,
        ST_NO_ROUTE = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_LOCAL_ID   = 1'd0,
        REG_NODE_LIMIT = 1'd1
    } reg_idx_t;

    // one node table entry
    typedef struct packed
    {
        logic              valid;
        logic [ID_W-1:0]   primary;
        logic [ID_W-1:0]   backup;
        logic [HOP_W-1:0]  hop;
        logic [TIME_W-1:0] ptime;
    } node_ent_t;

    // one search stack entry: node and whether it was reached by backup
    typedef struct packed
    {
        logic            alt;
        logic [ID_W-1:0] node;
    } stk_ent_t;

    function automatic logic [HOP_W-1:0] sat_hop(input logic [7:0] h);
        logic [HOP_W-1:0] r;
        r = (h > 8'(HOP_SAT)) ? HOP_SAT : h[HOP_W-1:0];
        return r;
    endfunction

    // parent update: old primary rotates into backup, or the new parent fills an empty backup
    function automatic node_ent_t set_parent(input node_ent_t e,
                                             input logic [ID_W-1:0] par,
                                             input logic [TIME_W-1:0] t);
        node_ent_t r;
        r = e;
        if (e.primary != par)
        begin
            r.backup  = (e.backup == '0) ? par : e.primary;
            r.primary = par;
        end
        r.ptime = t;
        return r;
    endfunction

endpackage

### rtl/mpre_req_if.sv
// ----------------------------------------------------------------------------
// mpre_req_if
// request channel of the mesh parent route engine
// ----------------------------------------------------------------------------
interface mpre_req_if;
    import mpre_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [ID_W-1:0]   node_id;
    logic              node_valid;
    logic [TIME_W-1:0] slot_time;

    modport source (output valid, op, node_id, node_valid, slot_time, input ready);
    modport sink   (input valid, op, node_id, node_valid, slot_time, output ready);
endinterface

### rtl/mpre_rsp_if.sv
// ----------------------------------------------------------------------------
// mpre_rsp_if
// result channel of the mesh parent route engine
// ----------------------------------------------------------------------------
interface mpre_rsp_if;
    import mpre_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  hop_node;
    logic [LEN_W-1:0] path_length;
    logic             last;

    modport source (output valid, status, hop_node, path_length, last, input ready);
    modport sink   (input valid, status, hop_node, path_length, last, output ready);
endinterface

### rtl/mesh_parent_route_engine.sv
// ----------------------------------------------------------------------------
// mesh_parent_route_engine
// per-node parent table with relay buffer, route commit and depth first search
// requests: one at a time, all node table accesses go through one read port
// reset: async active low, then a clearing pass zeroes all MAX_NODES entries
//   (1024 by default) of the node table before the first request is taken
// ----------------------------------------------------------------------------
module mesh_parent_route_engine
#(
    parameter int MAX_NODES  = mpre_pkg::MAX_NODES_DEF,
    parameter int MAX_RELAYS = mpre_pkg::MAX_RELAYS_DEF,
    parameter int MAX_DEPTH  = mpre_pkg::MAX_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mpre_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mpre_pkg::ID_W-1:0]      cfg_wdata,
    mpre_req_if.sink                       in_ch,
    mpre_rsp_if.source                     out_ch
);
    import mpre_pkg::*;

    // table, relay buffer and search stack geometry
    localparam int AW  = $clog2(MAX_NODES);
    localparam int RCW = $clog2(MAX_RELAYS + 1);
    localparam int RAW = (MAX_RELAYS > 1) ? $clog2(MAX_RELAYS) : 1;
    localparam int HW  = RCW + 1;
    localparam int SAW = $clog2(MAX_DEPTH + 1);
    localparam int SLW = $clog2(MAX_DEPTH + 2);

    typedef enum logic [4:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SV_RD,
        S_SV_WR,
        S_AP_SCAN,
        S_AP_CMP,
        S_R0_RD,
        S_R0_CHK,
        S_R0_VAL,
        S_SRC_CHK,
        S_SRC_WR,
        S_WALK_START,
        S_WALK_RD,
        S_WALK_CHK,
        S_WALK_VAL,
        S_COMMIT_DONE,
        S_ENTER,
        S_LC_RD,
        S_LC_CMP,
        S_NODE_RD,
        S_NODE_GOT,
        S_TRY_B,
        S_FAIL_UP,
        S_POP,
        S_PAR_GOT,
        S_PAR_RD,
        S_PAR_B,
        S_SUCC,
        S_OUT_RD,
        S_OUT_EMIT,
        S_EMIT
    } state_t;

    // node table, relay buffer and search stack
    node_ent_t        tbl_mem [MAX_NODES];
    logic [ID_W-1:0]  buf_mem [MAX_RELAYS];
    stk_ent_t         stk_mem [MAX_DEPTH + 1];

    node_ent_t        tbl_q;
    logic [ID_W-1:0]  buf_q;
    stk_ent_t         stk_q;

    logic [AW-1:0]    tbl_raddr;
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    node_ent_t        tbl_wdata;
    logic [RAW-1:0]   buf_raddr;
    logic             buf_we;
    logic [RAW-1:0]   buf_waddr;
    logic [SAW-1:0]   stk_raddr;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr;
    stk_ent_t         stk_wdata;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              vl_reg, vl_next;
    logic [TIME_W-1:0] tm_reg, tm_next;
    logic [ID_W-1:0]   local_reg, local_next;
    logic [ID_W-1:0]   limit_reg, limit_next;
    logic [RCW-1:0]    count_reg, count_next;
    logic              dup_reg, dup_next;
    logic              have_reg, have_next;
    logic [ID_W-1:0]   par_reg, par_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic [ID_W-1:0]   up_reg, up_next;
    logic [HW-1:0]     hop_reg, hop_next;
    logic [ID_W-1:0]   b_reg, b_next;
    logic [RCW-1:0]    ridx_reg, ridx_next;
    logic [SLW-1:0]    len_reg, len_next;
    logic [SLW-1:0]    sidx_reg, sidx_next;
    logic [AW-1:0]     clr_reg, clr_next;
    status_t           res_reg, res_next;
    logic              ov_reg, ov_next;
    status_t           ost_reg, ost_next;
    logic [ID_W-1:0]   onode_reg, onode_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic              olast_reg, olast_next;

    logic              can_emit;

    function automatic logic node_ok(input logic [ID_W-1:0] n);
        return 32'(n) < 32'(MAX_NODES);
    endfunction

    // a relay usable for a parent walk, before its valid mark is seen
    function automatic logic relay_pre_ok(input logic [ID_W-1:0] n,
                                          input logic [ID_W-1:0] loc,
                                          input logic [ID_W-1:0] lim);
        return (n != '0) && (n != loc) && (n <= lim) && node_ok(n);
    endfunction

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = ov_reg;
    assign out_ch.status      = ost_reg;
    assign out_ch.hop_node    = onode_reg;
    assign out_ch.path_length = olen_reg;
    assign out_ch.last        = olast_reg;

    // output register frees when taken
    assign can_emit = !ov_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        vl_next    = vl_reg;
        tm_next    = tm_reg;
        local_next = local_reg;
        limit_next = limit_reg;
        count_next = count_reg;
        dup_next   = dup_reg;
        have_next  = have_reg;
        par_next   = par_reg;
        cur_next   = cur_reg;
        up_next    = up_reg;
        hop_next   = hop_reg;
        b_next     = b_reg;
        ridx_next  = ridx_reg;
        len_next   = len_reg;
        sidx_next  = sidx_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        ost_next   = ost_reg;
        onode_next = onode_reg;
        olen_next  = olen_reg;
        olast_next = olast_reg;

        tbl_raddr = '0;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        buf_raddr = '0;
        buf_we    = 1'b0;
        buf_waddr = '0;
        stk_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        // configuration writes, taken in any state
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCAL_ID:   local_next = cfg_wdata;
                REG_NODE_LIMIT: limit_next = cfg_wdata;
                default:        ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    id_next  = in_ch.node_id;
                    vl_next  = in_ch.node_valid;
                    tm_next  = in_ch.slot_time;
                    res_next = ST_DONE;
                    case (op_t'(in_ch.op))
                        OP_SET_VALID:
                        begin
                            state_next = node_ok(in_ch.node_id) ? S_SV_RD : S_EMIT;
                        end
                        OP_APPEND:
                        begin
                            ridx_next = '0;
                            if (count_reg < RCW'(MAX_RELAYS))
                            begin
                                state_next = S_AP_SCAN;
                            end
                            else
                            begin
                                res_next   = ST_OVERFLOW;
                                state_next = S_EMIT;
                            end
                        end
                        OP_COMMIT:
                        begin
                            if (count_reg == '0)
                            begin
                                par_next   = local_reg;
                                have_next  = 1'b1;
                                state_next = S_SRC_CHK;
                            end
                            else
                            begin
                                state_next = S_R0_RD;
                            end
                        end
                        OP_SELECT:
                        begin
                            len_next   = '0;
                            cur_next   = in_ch.node_id;
                            state_next = S_ENTER;
                        end
                        default: ;
                    endcase
                end
            end

            // set valid: read, modify, write
            S_SV_RD:
            begin
                tbl_raddr  = AW'(id_reg);
                state_next = S_SV_WR;
            end

            S_SV_WR:
            begin
                tbl_we          = 1'b1;
                tbl_waddr       = AW'(id_reg);
                tbl_wdata       = tbl_q;
                tbl_wdata.valid = vl_reg;
                state_next      = S_EMIT;
            end

            // append: compare against held relays to keep a duplicate flag
            S_AP_SCAN:
            begin
                buf_raddr = RAW'(ridx_reg);
                if (ridx_reg == count_reg)
                begin
                    buf_we     = 1'b1;
                    buf_waddr  = RAW'(count_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_AP_CMP;
                end
            end

            S_AP_CMP:
            begin
                if (buf_q == id_reg)
                begin
                    dup_next = 1'b1;
                end
                ridx_next  = ridx_reg + 1'b1;
                state_next = S_AP_SCAN;
            end

            // commit: source parent from the first relay
            S_R0_RD:
            begin
                buf_raddr  = '0;
                state_next = S_R0_CHK;
            end

            S_R0_CHK:
            begin
                tbl_raddr = AW'(buf_q);
                par_next  = buf_q;
                if ((buf_q != '0) && (buf_q <= limit_reg) && node_ok(buf_q))
                begin
                    state_next = S_R0_VAL;
                end
                else
                begin
                    have_next  = 1'b0;
                    state_next = S_SRC_CHK;
                end
            end

            S_R0_VAL:
            begin
                have_next  = tbl_q.valid;
                state_next = S_SRC_CHK;
            end

            S_SRC_CHK:
            begin
                tbl_raddr = AW'(id_reg);
                if (have_reg && (id_reg != local_reg) && (id_reg <= limit_reg)
                    && node_ok(id_reg))
                begin
                    state_next = S_SRC_WR;
                end
                else
                begin
                    state_next = S_WALK_START;
                end
            end

            S_SRC_WR:
            begin
                tbl_we        = 1'b1;
                tbl_waddr     = AW'(id_reg);
                tbl_wdata     = set_parent(tbl_q, par_reg, tm_reg);
                tbl_wdata.hop = sat_hop(8'(count_reg) + 8'd2);
                state_next    = S_WALK_START;
            end

            // relay walk from the gateway side, last relay first
            S_WALK_START:
            begin
                ridx_next = count_reg;
                up_next   = local_reg;
                hop_next  = HW'(1);
                if (dup_reg || (count_reg == '0))
                begin
                    state_next = S_COMMIT_DONE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                buf_raddr  = RAW'(ridx_reg - 1'b1);
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                tbl_raddr = AW'(buf_q);
                cur_next  = buf_q;
                if (relay_pre_ok(buf_q, local_reg, limit_reg))
                begin
                    state_next = S_WALK_VAL;
                end
                else
                begin
                    state_next = S_COMMIT_DONE;
                end
            end

            S_WALK_VAL:
            begin
                if (!tbl_q.valid)
                begin
                    state_next = S_COMMIT_DONE;
                end
                else
                begin
                    tbl_we        = 1'b1;
                    tbl_waddr     = AW'(cur_reg);
                    tbl_wdata     = set_parent(tbl_q, up_reg, tm_reg + TIME_W'(hop_reg));
                    tbl_wdata.hop = sat_hop(8'(hop_reg) + 8'd1);
                    up_next       = cur_reg;
                    hop_next      = hop_reg + 1'b1;
                    ridx_next     = ridx_reg - 1'b1;
                    state_next    = (ridx_reg == RCW'(1)) ? S_COMMIT_DONE : S_WALK_RD;
                end
            end

            S_COMMIT_DONE:
            begin
                count_next = '0;
                dup_next   = 1'b0;
                state_next = S_EMIT;
            end

            // search: enter a frame at depth len for node cur
            S_ENTER:
            begin
                sidx_next = '0;
                if (len_reg > SLW'(MAX_DEPTH))
                begin
                    state_next = S_FAIL_UP;
                end
                else if (len_reg >= SLW'(2))
                begin
                    state_next = S_LC_RD;
                end
                else
                begin
                    state_next = S_NODE_RD;
                end
            end

            // loop rejection against the path below this frame
            S_LC_RD:
            begin
                stk_raddr  = SAW'(sidx_reg);
                state_next = S_LC_CMP;
            end

            S_LC_CMP:
            begin
                if (stk_q.node == cur_reg)
                begin
                    state_next = S_FAIL_UP;
                end
                else if ((sidx_reg + SLW'(2)) < len_reg)
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_LC_RD;
                end
                else
                begin
                    state_next = S_NODE_RD;
                end
            end

            S_NODE_RD:
            begin
                tbl_raddr = AW'(cur_reg);
                if (node_ok(cur_reg))
                begin
                    state_next = S_NODE_GOT;
                end
                else
                begin
                    b_next     = '0;
                    state_next = S_TRY_B;
                end
            end

            // primary parent first
            S_NODE_GOT:
            begin
                b_next = tbl_q.backup;
                if (tbl_q.primary == '0)
                begin
                    state_next = S_TRY_B;
                end
                else if (tbl_q.primary == local_reg)
                begin
                    state_next = S_SUCC;
                end
                else
                begin
                    stk_we         = 1'b1;
                    stk_waddr      = SAW'(len_reg);
                    stk_wdata.alt  = 1'b0;
                    stk_wdata.node = tbl_q.primary;
                    len_next       = len_reg + 1'b1;
                    cur_next       = tbl_q.primary;
                    state_next     = S_ENTER;
                end
            end

            S_TRY_B:
            begin
                if (b_reg == '0)
                begin
                    state_next = S_FAIL_UP;
                end
                else if (b_reg == local_reg)
                begin
                    state_next = S_SUCC;
                end
                else
                begin
                    stk_we         = 1'b1;
                    stk_waddr      = SAW'(len_reg);
                    stk_wdata.alt  = 1'b1;
                    stk_wdata.node = b_reg;
                    len_next       = len_reg + 1'b1;
                    cur_next       = b_reg;
                    state_next     = S_ENTER;
                end
            end

            // frame failed: pop back to its parent frame
            S_FAIL_UP:
            begin
                stk_raddr = SAW'(len_reg - 1'b1);
                if (len_reg == '0)
                begin
                    res_next   = ST_NO_ROUTE;
                    state_next = S_EMIT;
                end
                else
                begin
                    len_next   = len_reg - 1'b1;
                    state_next = S_POP;
                end
            end

            S_POP:
            begin
                stk_raddr = SAW'(len_reg - 1'b1);
                if (stk_q.alt)
                begin
                    state_next = S_FAIL_UP;
                end
                else if (len_reg == '0)
                begin
                    cur_next   = id_reg;
                    state_next = S_PAR_RD;
                end
                else
                begin
                    state_next = S_PAR_GOT;
                end
            end

            S_PAR_GOT:
            begin
                cur_next   = stk_q.node;
                state_next = S_PAR_RD;
            end

            S_PAR_RD:
            begin
                tbl_raddr = AW'(cur_reg);
                if (node_ok(cur_reg))
                begin
                    state_next = S_PAR_B;
                end
                else
                begin
                    b_next     = '0;
                    state_next = S_TRY_B;
                end
            end

            S_PAR_B:
            begin
                b_next     = tbl_q.backup;
                state_next = S_TRY_B;
            end

            S_SUCC:
            begin
                sidx_next = '0;
                if (len_reg == '0)
                begin
                    res_next   = ST_DONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end

            // path out, gateway side first
            S_OUT_RD:
            begin
                stk_raddr  = SAW'(len_reg - 1'b1 - sidx_reg);
                state_next = S_OUT_EMIT;
            end

            S_OUT_EMIT:
            begin
                stk_raddr = SAW'(len_reg - 1'b1 - sidx_reg);
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_ROUTE;
                    onode_next = stk_q.node;
                    olen_next  = LEN_W'(len_reg);
                    olast_next = ((sidx_reg + 1'b1) == len_reg);
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = ((sidx_reg + 1'b1) == len_reg) ? S_IDLE : S_OUT_RD;
                end
            end

            S_EMIT:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_reg;
                    onode_next = id_reg;
                    olen_next  = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            local_reg <= LOCAL_ID_RST;
            limit_reg <= NODE_LIMIT_RST;
            count_reg <= '0;
            dup_reg   <= 1'b0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            local_reg <= local_next;
            limit_reg <= limit_next;
            count_reg <= count_next;
            dup_reg   <= dup_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        vl_reg    <= vl_next;
        tm_reg    <= tm_next;
        have_reg  <= have_next;
        par_reg   <= par_next;
        cur_reg   <= cur_next;
        up_reg    <= up_next;
        hop_reg   <= hop_next;
        b_reg     <= b_next;
        ridx_reg  <= ridx_next;
        len_reg   <= len_next;
        sidx_reg  <= sidx_next;
        res_reg   <= res_next;
        ost_reg   <= ost_next;
        onode_reg <= onode_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    // node table, one read and one write port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_q <= tbl_mem[tbl_raddr];
    end

    // relay buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= id_reg;
        end
        buf_q <= buf_mem[buf_raddr];
    end

    // search stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stk_mem[stk_raddr];
    end

endmodule

### rtl/mpre_checker.sv
// ----------------------------------------------------------------------------
// mpre_checker
// port-level checks of the mesh parent route engine, bound to the top level
// ----------------------------------------------------------------------------
`include "mesh_parent_route_engine_assert.svh"

module mpre_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    out_status,
    input logic [mpre_pkg::ID_W-1:0]     out_hop_node,
    input logic [mpre_pkg::LEN_W-1:0]    out_path_length,
    input logic                          out_last
);
    import mpre_pkg::*;

    logic [ID_W+LEN_W+2:0] out_payload;

    assign out_payload = {out_status, out_hop_node, out_path_length, out_last};

    // a taken request keeps the block busy
    `MPRE_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `MPRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

    // anything but a route element is a single final result with no length
    `MPRE_ASSERT_IMPL(a_single_result, out_valid && (out_status != ST_ROUTE), out_last && (out_path_length == '0))

    // more route elements pending: no new request taken
    `MPRE_ASSERT_IMPL(a_route_pending, out_valid && (out_status == ST_ROUTE) && !out_last, !in_ready)

endmodule

bind mesh_parent_route_engine mpre_checker u_mpre_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_hop_node    (out_ch.hop_node),
    .out_path_length (out_ch.path_length),
    .out_last        (out_ch.last)
);

### dv/tb_mesh_parent_route_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_parent_route_engine
// drives set-valid, relay append, commit and route select requests through
// the engine, predicts every result from a local copy of the node table and
// checks each result field by field, across several register settings
// ----------------------------------------------------------------------------
module tb_mesh_parent_route_engine;
    import mpre_pkg::*;

    localparam int RELAY_CAP   = 16;
    localparam int DEPTH_LIMIT = 12;
    localparam int STALL_LIMIT = 1000000;   // cycles without any handshake
    localparam int RUN_LIMIT   = 20000000;

    typedef struct packed
    {
        op_t         op;
        logic [9:0]  id;
        logic        nv;
        logic [31:0] ts;
    } route_req_t;

    typedef struct packed
    {
        status_t    st;
        logic [9:0] node;
        logic [3:0] len;
        logic       last;
    } route_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0] cfg_wdata;

    mpre_req_if req_ch ();
    mpre_rsp_if rsp_ch ();

    mesh_parent_route_engine i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch)
    );

    // predicted node table; hop counts and parent times never reach the
    // outputs, so only valid marks and parents are kept
    logic       node_ok [1024];
    logic [9:0] prim_par [1024];
    logic [9:0] bkup_par [1024];
    logic [9:0] relay_q [RELAY_CAP];
    int         relay_cnt;
    logic [9:0] route_stack [DEPTH_LIMIT+1];
    int         route_len;
    logic [9:0] cur_local;
    logic [9:0] cur_limit;

    route_req_t pend_q[$];
    route_res_t result_q[$];

    int n_req = 0, n_res = 0, n_route = 0, n_overflow = 0, n_noroute = 0, n_err = 0;
    int idle_cycles = 0, run_cycles = 0;

    // idling controls, set per phase by the stimulus
    bit no_gaps;
    int stall_pct;
    int hold_req, hold_seen, hold_cnt;
    int burst_left, gap_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic move_parent(input logic [9:0] nd, input logic [9:0] par);
        if (prim_par[nd] != par)
        begin
            bkup_par[nd] = (bkup_par[nd] == '0) ? par : prim_par[nd];
            prim_par[nd] = par;
        end
    endtask

    function automatic bit relay_usable(input logic [9:0] id);
        return id != 0 && id != cur_local && id <= cur_limit && node_ok[id];
    endfunction

    // depth first toward the concentrator, primary before backup
    function automatic bit find_route(input logic [9:0] nd);
        logic [9:0] p;
        logic [9:0] b;
        if (route_len > DEPTH_LIMIT)
            return 1'b0;
        for (int i = 0; i + 1 < route_len; i++)
            if (route_stack[i] == nd)
                return 1'b0;
        p = prim_par[nd];
        b = bkup_par[nd];
        if (p != 0)
        begin
            if (p == cur_local)
                return 1'b1;
            route_stack[route_len] = p;
            route_len++;
            if (find_route(p))
                return 1'b1;
            route_len--;
        end
        if (b != 0)
        begin
            if (b == cur_local)
                return 1'b1;
            route_stack[route_len] = b;
            route_len++;
            if (find_route(b))
                return 1'b1;
            route_len--;
        end
        return 1'b0;
    endfunction

    task automatic add_result(input status_t st, input logic [9:0] nd,
                              input logic [3:0] len, input logic last);
        route_res_t r;
        r.st = st;
        r.node = nd;
        r.len = len;
        r.last = last;
        result_q.push_back(r);
    endtask

    task automatic predict_request(input route_req_t r);
        logic [9:0] par;
        logic [9:0] up;
        bit have;
        bit dup;
        case (r.op)
            OP_SET_VALID:
            begin
                node_ok[r.id] = r.nv;
                add_result(ST_DONE, r.id, 4'd0, 1'b1);
            end
            OP_APPEND:
            begin
                if (relay_cnt < RELAY_CAP)
                begin
                    relay_q[relay_cnt] = r.id;
                    relay_cnt++;
                    add_result(ST_DONE, r.id, 4'd0, 1'b1);
                end
                else
                begin
                    n_overflow++;
                    add_result(ST_OVERFLOW, r.id, 4'd0, 1'b1);
                end
            end
            OP_COMMIT:
            begin
                have = 1'b0;
                par = '0;
                if (relay_cnt == 0)
                begin
                    par = cur_local;
                    have = 1'b1;
                end
                else if (relay_q[0] != 0 && relay_q[0] <= cur_limit && node_ok[relay_q[0]])
                begin
                    par = relay_q[0];
                    have = 1'b1;
                end
                if (have && r.id != cur_local && r.id <= cur_limit)
                    move_parent(r.id, par);
                // a repeated relay id leaves the relays untouched
                dup = 1'b0;
                for (int i = 0; i + 1 < relay_cnt; i++)
                    for (int j = i + 1; j < relay_cnt; j++)
                        if (relay_q[i] == relay_q[j])
                            dup = 1'b1;
                if (!dup)
                begin
                    up = cur_local;
                    for (int i = relay_cnt; i > 0; i--)
                    begin
                        if (!relay_usable(relay_q[i-1]))
                            break;
                        move_parent(relay_q[i-1], up);
                        up = relay_q[i-1];
                    end
                end
                relay_cnt = 0;
                add_result(ST_DONE, r.id, 4'd0, 1'b1);
            end
            default:
            begin
                route_len = 0;
                if (!find_route(r.id))
                begin
                    n_noroute++;
                    add_result(ST_NO_ROUTE, r.id, 4'd0, 1'b1);
                end
                else if (route_len == 0)
                    add_result(ST_DONE, r.id, 4'd0, 1'b1);
                else
                begin
                    n_route++;
                    for (int k = 0; k < route_len; k++)
                        add_result(ST_ROUTE, route_stack[route_len-1-k], 4'(route_len),
                                   k + 1 == route_len);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of requests with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.op         <= '0;
            req_ch.node_id    <= '0;
            req_ch.node_valid <= 1'b0;
            req_ch.slot_time  <= '0;
            burst_left        <= 0;
            gap_left          <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left > 0 && !no_gaps)
            begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                req_ch.valid      <= 1'b1;
                req_ch.op         <= pend_q[0].op;
                req_ch.node_id    <= pend_q[0].id;
                req_ch.node_valid <= pend_q[0].nv;
                req_ch.slot_time  <= pend_q[0].ts;
                void'(pend_q.pop_front());
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt     <= 0;
            hold_seen    <= 0;
        end
        else if (hold_cnt > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end
        else if (hold_req != hold_seen)
        begin
            // engine fills up and must stall its request side
            hold_seen    <= hold_req;
            hold_cnt     <= 400;
            rsp_ch.ready <= 1'b0;
        end
        else if (no_gaps)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict accepted requests, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        route_res_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                route_req_t r;
                r.op = op_t'(req_ch.op);
                r.id = req_ch.node_id;
                r.nv = req_ch.node_valid;
                r.ts = req_ch.slot_time;
                predict_request(r);
                n_req++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_res++;
                if (result_q.size() == 0)
                begin
                    $error("unexpected result: status %0d hop_node %0d",
                           rsp_ch.status, rsp_ch.hop_node);
                    n_err++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp_ch.status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, rsp_ch.status);
                        n_err++;
                    end
                    if (rsp_ch.hop_node !== want.node)
                    begin
                        $error("hop_node: expected %0d, got %0d", want.node, rsp_ch.hop_node);
                        n_err++;
                    end
                    if (rsp_ch.path_length !== want.len)
                    begin
                        $error("path_length: expected %0d, got %0d", want.len,
                               rsp_ch.path_length);
                        n_err++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        n_err++;
                    end
                end
            end
        end
    end

    // watchdog: no handshake for too long, or run far too long
    always @(posedge clk)
    begin
        run_cycles <= run_cycles + 1;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT || run_cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", run_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(input op_t op, input logic [9:0] id, input logic nv);
        route_req_t r;
        r.op = op;
        r.id = id;
        r.nv = nv;
        r.ts = $urandom;
        pend_q.push_back(r);
    endtask

    // ids mostly from a small crowd so routes actually form
    function automatic logic [9:0] pick_id();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return 10'($urandom_range(0, 24));
        else if (k < 88)
            return cur_local;
        else if (k < 93)
            return cur_limit + 10'($urandom_range(0, 1));
        return 10'($urandom);
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_LOCAL_ID)
            cur_local = val;
        else
            cur_limit = val;
    endtask

    // sampled away from the clock edge so queue and handshake state are settled
    task automatic wait_drained();
        @(negedge clk);
        while (pend_q.size() != 0 || req_ch.valid || result_q.size() != 0 || !req_ch.ready)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    // well-formed route updates with random content, plus some noise
    task automatic queue_random(input int count);
        int made;
        int k;
        int nrel;
        made = 0;
        while (made < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 12)
            begin
                route_req_t r;
                r.op = op_t'($urandom_range(0, 3));
                r.id = 10'($urandom);
                r.nv = 1'($urandom);
                r.ts = $urandom;
                pend_q.push_back(r);
                made++;
            end
            else
            begin
                if (k < 40)
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_req(OP_SET_VALID, pick_id(), $urandom_range(0, 9) != 0);
                        made++;
                    end
                nrel = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 18)
                                                    : $urandom_range(0, 4);
                repeat (nrel)
                begin
                    queue_req(OP_APPEND, pick_id(), 1'($urandom));
                    made++;
                end
                queue_req(OP_COMMIT, pick_id(), 1'($urandom));
                queue_req(OP_SELECT, pick_id(), 1'($urandom));
                made += 2;
                if ($urandom_range(0, 1))
                begin
                    queue_req(OP_SELECT, pick_id(), 1'($urandom));
                    made++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [9:0] lid, input logic [9:0] lim,
                             input int count, input int pct, input bit hold);
        write_reg(REG_LOCAL_ID, lid);
        write_reg(REG_NODE_LIMIT, lim);
        stall_pct = pct;
        queue_random(count);
        if (hold)
            hold_req++;
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < 1024; i++)
        begin
            node_ok[i]  = 1'b0;
            prim_par[i] = '0;
            bkup_par[i] = '0;
        end
        relay_cnt = 0;
        cur_local = LOCAL_ID_RST;
        cur_limit = NODE_LIMIT_RST;
        no_gaps   = 1'b0;
        stall_pct = 30;
        hold_req  = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: id extremes, empty commit, chain, duplicate
        write_reg(REG_LOCAL_ID, 10'd1);
        write_reg(REG_NODE_LIMIT, 10'd1023);
        queue_req(OP_SET_VALID, 10'd0, 1'b1);
        queue_req(OP_SET_VALID, 10'd1023, 1'b1);
        queue_req(OP_SELECT, 10'd1023, 1'b0);     // never parented
        queue_req(OP_SELECT, 10'd1, 1'b0);        // the concentrator itself
        queue_req(OP_COMMIT, 10'd5, 1'b0);        // empty buffer: direct child
        queue_req(OP_SELECT, 10'd5, 1'b0);        // route with no relays
        queue_req(OP_SET_VALID, 10'd6, 1'b1);
        queue_req(OP_SET_VALID, 10'd7, 1'b1);
        queue_req(OP_APPEND, 10'd7, 1'b0);
        queue_req(OP_APPEND, 10'd6, 1'b0);
        queue_req(OP_COMMIT, 10'd8, 1'b0);        // relays walked back
        queue_req(OP_SELECT, 10'd8, 1'b0);
        queue_req(OP_APPEND, 10'd6, 1'b0);
        queue_req(OP_APPEND, 10'd6, 1'b0);
        queue_req(OP_COMMIT, 10'd9, 1'b0);        // duplicate relay
        queue_req(OP_COMMIT, 10'd1, 1'b0);        // source is the concentrator
        queue_req(OP_SET_VALID, 10'd10, 1'b1);
        queue_req(OP_SET_VALID, 10'd11, 1'b1);
        queue_req(OP_APPEND, 10'd11, 1'b0);
        queue_req(OP_COMMIT, 10'd10, 1'b0);
        queue_req(OP_APPEND, 10'd10, 1'b0);
        queue_req(OP_COMMIT, 10'd11, 1'b0);       // 11 now points at 10, and 10 at the concentrator with 11 as backup
        queue_req(OP_SELECT, 10'd10, 1'b0);       // primary parent is the concentrator
        queue_req(OP_SET_VALID, 10'd1023, 1'b0);
        wait_drained();

        // random phases over several register settings, one with no idling
        run_phase(10'd1, 10'd1023, 100, 30, 1'b0);
        run_phase(10'd17, 10'd40, 90, 50, 1'b1);
        no_gaps = 1'b1;
        run_phase(10'd1023, 10'd1023, 80, 0, 1'b0);
        no_gaps = 1'b0;
        run_phase(10'd0, 10'd15, 80, 20, 1'b0);
        run_phase(10'd2, 10'd0, 40, 60, 1'b0);

        $display("%0d requests, %0d results checked", n_req, n_res);
        $display("%0d routes found, %0d searches failed, %0d relay overflows",
                 n_route, n_noroute, n_overflow);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
